/* sv/srk_pkg.sv */
// Shared constants and types for the symmetric rank-k update block.
package srk_pkg;

	localparam int unsigned MAX_DIM_DEFAULT = 16;

	localparam int unsigned SIZE_W  = 5;
	localparam int unsigned SCALE_W = 17;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned CFG_W   = 17;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd16;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd13107;

	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd1;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	typedef struct packed {
		logic              capture;
		logic              load_we;
		logic              final_elem;
		logic              first;
		logic              rd_en;
		logic [SIZE_W-1:0] k;
		logic              emit;
	} srk_cmd_t;

endpackage

/* sv/srk_ram.sv */
// Generic RAM: one write port, two registered read ports.
module srk_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                            rdata_a,
	output logic [WIDTH-1:0]                            rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* sv/srk_ctrl.sv */
// Controller: accept decode, dot-product sequencing and result timing.
module srk_ctrl import srk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              func,
	input  logic [INDEX_W-1:0] row_index,
	input  logic [INDEX_W-1:0] col_index,
	input  logic [SIZE_W-1:0] n_eff,
	output logic              busy,
	output srk_cmd_t          cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH1,
		ST_FLUSH2,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] k_q;
	logic              accept;
	logic              in_range;
	logic [SIZE_W-1:0] n_last;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign n_last   = SIZE_W'(n_eff - 5'd1);
	assign in_range = (SIZE_W'(row_index) < n_eff) && (SIZE_W'(col_index) < n_eff);

	always_comb begin
		cmd            = '0;
		cmd.capture    = accept && func && in_range;
		cmd.load_we    = accept && !func && in_range;
		cmd.final_elem = (SIZE_W'(row_index) == n_last) && (SIZE_W'(col_index) == n_last);
		cmd.first      = (state_q == ST_RUN) && (k_q == '0);
		cmd.rd_en      = (state_q == ST_RUN);
		cmd.k          = k_q;
		cmd.emit       = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (cmd.capture) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_q == n_last) begin
						state_q <= ST_FLUSH1;
					end else begin
						k_q <= SIZE_W'(k_q + 5'd1);
					end
				end
				ST_FLUSH1: state_q <= ST_FLUSH2;
				ST_FLUSH2: state_q <= ST_DONE;
				ST_DONE:   state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q < n_eff))
		else $error("dot-product index past matrix size");

endmodule

/* sv/srk_dp.sv */
// Datapath: A store, shared multiplier, rounding accumulator and saturation.
module srk_dp import srk_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srk_cmd_t            cmd,
	input  logic [INDEX_W-1:0]  row_index,
	input  logic [INDEX_W-1:0]  col_index,
	input  logic signed [DATA_W-1:0] element_value,
	input  logic [SCALE_W-1:0]  scale,
	output logic                result_valid,
	output logic [INDEX_W-1:0]  out_row,
	output logic [INDEX_W-1:0]  out_col,
	output logic signed [DATA_W-1:0] updated_value,
	output logic                saturated,
	output logic                final_element
);

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [SIZE_W-1:0] r,
		input logic [SIZE_W-1:0] c);
		elem_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
	endfunction

	logic [INDEX_W-1:0]       row_q;
	logic [INDEX_W-1:0]       col_q;
	logic signed [DATA_W-1:0] val_q;
	logic                     final_q;

	logic [DATA_W-1:0]        rdata_a;
	logic [DATA_W-1:0]        rdata_b;
	logic                     rd_valid_s1;

	logic signed [DATA_W:0]   op_a;
	logic signed [DATA_W:0]   op_b;
	logic signed [2*DATA_W+1:0] prod_full;
	logic signed [ACC_W-1:0]  prod_s2;
	logic                     prod_valid_s2;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [DATA_W-1:0] sat_value;
	logic                     sat_flag;
	logic                     result_valid_q;

	srk_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_a_store (
		.clk     (clk),
		.we      (cmd.load_we),
		.waddr   (elem_addr(SIZE_W'(row_index), SIZE_W'(col_index))),
		.wdata   (element_value),
		.raddr_a (elem_addr(SIZE_W'(row_q), cmd.k)),
		.raddr_b (elem_addr(SIZE_W'(col_q), cmd.k)),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_comb begin
		if (rd_valid_s1) begin
			op_a = {rdata_a[DATA_W-1], rdata_a};
			op_b = {rdata_b[DATA_W-1], rdata_b};
		end else begin
			op_a = {val_q[DATA_W-1], val_q};
			op_b = {{(DATA_W+1-SCALE_W){1'b0}}, scale};
		end
	end

	assign prod_full = op_a * op_b;
	// round half up to Q16.16
	assign term = (prod_s2 + 64'sd32768) >>> 16;

	always_comb begin
		if (acc_q > 64'sd2147483647) begin
			sat_value = 32'sh7FFF_FFFF;
			sat_flag  = 1'b1;
		end else if (acc_q < -64'sd2147483648) begin
			sat_value = 32'sh8000_0000;
			sat_flag  = 1'b1;
		end else begin
			sat_value = acc_q[DATA_W-1:0];
			sat_flag  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q   <= row_index;
			col_q   <= col_index;
			val_q   <= element_value;
			final_q <= cmd.final_elem;
		end
		prod_s2 <= prod_full[ACC_W-1:0];
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (prod_valid_s2) begin
			acc_q <= acc_q + term;
		end
		if (cmd.emit) begin
			out_row       <= row_q;
			out_col       <= col_q;
			updated_value <= sat_value;
			saturated     <= sat_flag;
			final_element <= final_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1    <= 1'b0;
			prod_valid_s2  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_valid_s1    <= cmd.rd_en;
			prod_valid_s2  <= rd_valid_s1 || cmd.first;
			result_valid_q <= cmd.emit;
		end
	end

	assign result_valid = result_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.first |-> !rd_valid_s1)
		else $error("scale product collides with store read data");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!prod_valid_s2 && !rd_valid_s1))
		else $error("result emitted with products still in flight");

endmodule

/* sv/symmetric_rank_k_update_top.sv */
// Top level of the symmetric rank-k update block: config registers and unit wiring.
//
// An item is taken at a clock edge with start high and busy low. A load item
// (func 0) writes one A element into the internal store in that cycle and
// leaves busy low, as does any item whose row or column is not below the
// effective size (matrix_size capped at MAX_DIM); such items give no result.
// An update item (func 1) holds busy high while it runs, n being the
// effective size: one shared 33x33 multiplier takes the alpha*B product and
// then one A*A product per cycle from the two read ports of the A store, n
// in all; the flush states then drain the multiply and accumulate stages and
// the sum is saturated. The result appears on the output ports for exactly
// one cycle, marked by result_valid, in the cycle in which busy falls; the
// receiver cannot stall, so it must take every transfer in that cycle. Every
// A entry read by an update must have been loaded since reset. Configuration
// writes must go in while busy is low, which the block itself does not enforce.
module symmetric_rank_k_update_top import srk_pkg::*; #(
	parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [INDEX_W-1:0]        row_index,
	input  logic [INDEX_W-1:0]        col_index,
	input  logic signed [DATA_W-1:0]  element_value,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output logic                      result_valid,
	output logic [INDEX_W-1:0]        out_row,
	output logic [INDEX_W-1:0]        out_col,
	output logic signed [DATA_W-1:0]  updated_value,
	output logic                      saturated,
	output logic                      final_element
);

	logic [SIZE_W-1:0]  matrix_size_q;
	logic [SCALE_W-1:0] scale_factor_q;
	logic [SIZE_W-1:0]  n_eff;
	srk_cmd_t           cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q  <= SIZE_RESET;
			scale_factor_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATRIX_SIZE:  matrix_size_q  <= cfg_data[SIZE_W-1:0];
				CFG_SCALE_FACTOR: scale_factor_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_eff = (32'(matrix_size_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : matrix_size_q;

	srk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.row_index (row_index),
		.col_index (col_index),
		.n_eff     (n_eff),
		.busy      (busy),
		.cmd       (cmd)
	);

	srk_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.scale         (scale_factor_q),
		.result_valid  (result_valid),
		.out_row       (out_row),
		.out_col       (out_col),
		.updated_value (updated_value),
		.saturated     (saturated),
		.final_element (final_element)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result transfer while still busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func && (SIZE_W'(row_index) < n_eff)
			&& (SIZE_W'(col_index) < n_eff)) |=> busy)
		else $error("update item accepted without starting");

endmodule
